// ===== hw/rtl/ssm_pkg.sv =====
`default_nettype none
package ssm_pkg;

  // width of one stored or merged word
  localparam int WORD_W = 32;

  typedef logic signed [WORD_W-1:0] ssm_word_t;
  typedef logic [1:0] ssm_action_t;

  // action codes
  localparam ssm_action_t ACT_APPEND_A = 2'd0;
  localparam ssm_action_t ACT_APPEND_B = 2'd1;
  localparam ssm_action_t ACT_MERGE    = 2'd2;

  // which sequences still hold unread words
  typedef struct packed {
    logic a_left;
    logic b_left;
  } ssm_avail_t;

endpackage
`default_nettype wire

// ===== hw/rtl/sorted_sequence_merge.sv =====
// Append (action A or B): busy stays low; the next word may follow at once.
// Merge: each stored word goes through a RAM read state and then a compare and emit
//   state (ST_READ, then ST_EMIT); an empty merge gives its single result in the cycle
//   after start. busy is high for the whole run of a non-empty merge.
// Results are registered and strobed for one cycle; the receiver cannot stall.
// Reset (rst, synchronous, active high) empties both stores and clears the overflow flag.
`default_nettype none
module sorted_sequence_merge #(
  parameter int DEPTH = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire ssm_pkg::ssm_action_t action,
  input  wire ssm_pkg::ssm_word_t  value,
  output logic                     strobe,
  output ssm_pkg::ssm_word_t       merged_value,
  output logic                     last,
  output logic                     empty_res,
  output logic                     overflowed
);
  import ssm_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]    state;
  logic [CW-1:0] count_a, count_b;
  logic [CW-1:0] ia, ib, ia_next, ib_next;
  logic          overflow_seen;

  logic          accept;
  logic          we_a, we_b;
  logic [AW-1:0] raddr_a, raddr_b;
  ssm_word_t     a_word, b_word;
  ssm_avail_t    avail;
  logic          take_a;
  logic          fin;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  // store writes for appends that fit
  assign we_a = accept && (action == ACT_APPEND_A) && (count_a < DEPTH_C);
  assign we_b = accept && (action == ACT_APPEND_B) && (count_b < DEPTH_C);

  // read heads; an exhausted index wraps but its data is never taken
  assign raddr_a = ia[AW-1:0];
  assign raddr_b = ib[AW-1:0];

  ssm_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_store_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (count_a[AW-1:0]),
    .wdata (value),
    .raddr (raddr_a),
    .rdata (a_word)
  );

  ssm_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_store_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (count_b[AW-1:0]),
    .wdata (value),
    .raddr (raddr_b),
    .rdata (b_word)
  );

  // head selection
  assign avail.a_left = (ia < count_a);
  assign avail.b_left = (ib < count_b);

  ssm_pick u_pick (
    .avail  (avail),
    .a_word (a_word),
    .b_word (b_word),
    .take_a (take_a)
  );

  assign ia_next = ia + CW'(take_a);
  assign ib_next = ib + CW'(!take_a);
  assign fin     = (ia_next == count_a) && (ib_next == count_b);

  // sequencer and counts
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      count_a       <= '0;
      count_b       <= '0;
      ia            <= '0;
      ib            <= '0;
      overflow_seen <= 1'b0;
      strobe        <= 1'b0;
    end else begin
      strobe <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            case (action)
              ACT_APPEND_A: begin
                if (count_a < DEPTH_C) count_a <= count_a + CW'(1);
                else overflow_seen <= 1'b1;
              end
              ACT_APPEND_B: begin
                if (count_b < DEPTH_C) count_b <= count_b + CW'(1);
                else overflow_seen <= 1'b1;
              end
              ACT_MERGE: begin
                if (count_a == '0 && count_b == '0) begin
                  strobe        <= 1'b1;
                  overflow_seen <= 1'b0;
                end else begin
                  ia    <= '0;
                  ib    <= '0;
                  state <= ST_READ;
                end
              end
              default: ;
            endcase
          end
        end
        ST_READ: begin
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          strobe <= 1'b1;
          ia     <= ia_next;
          ib     <= ib_next;
          if (fin) begin
            count_a       <= '0;
            count_b       <= '0;
            overflow_seen <= 1'b0;
            state         <= ST_IDLE;
          end else begin
            state <= ST_READ;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (state == ST_EMIT) begin
      merged_value <= take_a ? a_word : b_word;
      last         <= fin;
      empty_res    <= 1'b0;
      overflowed   <= overflow_seen;
    end else if (accept && action == ACT_MERGE) begin
      merged_value <= '0;
      last         <= 1'b1;
      empty_res    <= 1'b1;
      overflowed   <= overflow_seen;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/ssm_ram.sv =====
`default_nettype none
module ssm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== hw/rtl/ssm_pick.sv =====
`default_nettype none
module ssm_pick (
  input  wire ssm_pkg::ssm_avail_t avail,
  input  wire ssm_pkg::ssm_word_t  a_word,
  input  wire ssm_pkg::ssm_word_t  b_word,
  output logic                     take_a
);
  import ssm_pkg::*;

  logic a_less;

  // shared signed compare; ties go to B
  assign a_less = (a_word < b_word);
  assign take_a = avail.a_left && (!avail.b_left || a_less);

endmodule
`default_nettype wire

// ===== hw/rtl/ssm_checker.sv =====
`default_nettype none
module ssm_checker (
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 start,
  input wire logic                 busy,
  input wire ssm_pkg::ssm_action_t action,
  input wire logic                 strobe,
  input wire ssm_pkg::ssm_word_t   merged_value,
  input wire logic                 last,
  input wire logic                 empty_res
);
  import ssm_pkg::*;

  // an empty merge is a single, final, zero word
  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    strobe && empty_res |-> last && (merged_value == '0))
    else $error("empty result not final or not zero");

  // the final word of a run releases the block
  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    strobe && last |-> !busy)
    else $error("busy still high on final word");

  // more words to come keeps the block busy
  a_mid_busy: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |-> busy)
    else $error("block idle in the middle of a run");

  // an accepted merge either answers at once or starts a run
  a_merge_reacts: assert property (@(posedge clk) disable iff (rst)
    start && !busy && action == ACT_MERGE |=> strobe || busy)
    else $error("merge request ignored");

  // appends and unused action codes never produce a word
  a_append_silent: assert property (@(posedge clk) disable iff (rst)
    start && !busy && action != ACT_MERGE |=> !strobe)
    else $error("word emitted after an append");

endmodule

bind sorted_sequence_merge ssm_checker u_ssm_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .action       (action),
  .strobe       (strobe),
  .merged_value (merged_value),
  .last         (last),
  .empty_res    (empty_res)
);
`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import ssm_pkg::*;

  localparam int DEPTH = 16;
  localparam int RANDOM_WORDS = 250;
  localparam int TAIL_CYCLES = 4 * DEPTH + 8;
  localparam ssm_action_t ACT_UNUSED = 2'd3;
  localparam ssm_word_t WORD_MIN = 32'sh8000_0000;
  localparam ssm_word_t WORD_MAX = 32'sh7FFF_FFFF;

  // one word for the block
  typedef struct {
    ssm_action_t act;
    ssm_word_t   val;
    bit          drain;  // hold off until every merge result is back
  } load_word_t;

  // one merged output
  typedef struct {
    ssm_word_t val;
    bit        last;
    bit        empty;
    bit        ovf;
  } merge_out_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  ssm_action_t action = ACT_APPEND_A;
  ssm_word_t   value = '0;
  logic        busy;
  logic        strobe;
  ssm_word_t   merged_value;
  logic        last;
  logic        empty_res;
  logic        overflowed;

  sorted_sequence_merge #(.DEPTH(DEPTH)) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .action(action),
    .value(value),
    .strobe(strobe),
    .merged_value(merged_value),
    .last(last),
    .empty_res(empty_res),
    .overflowed(overflowed)
  );

  // shadow of the two stores and the dropped-load flag
  ssm_word_t  held_a[$];
  ssm_word_t  held_b[$];
  bit         dropped_load;

  merge_out_t merged_expect[$];
  load_word_t word_queue[$];
  ssm_word_t  run_a[$];
  ssm_word_t  run_b[$];
  merge_out_t got_out;

  int errors;
  int words_total;
  int words_counted;
  int words_accepted;
  int merges_seen;
  int results_seen;
  int empty_merges;
  int overflow_merges;
  int burst_left;
  int gap_left;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("timeout at %0t", $time);
    $display("DONE: errors detected");
    $finish;
  end

  // work out what one accepted word does to the stores and what it emits
  task automatic predict_word(input ssm_action_t act, input ssm_word_t val);
    merge_out_t r;
    int total;
    int k;
    case (act)
      ACT_APPEND_A: begin
        if (held_a.size() < DEPTH) held_a.push_back(val);
        else dropped_load = 1'b1;
      end
      ACT_APPEND_B: begin
        if (held_b.size() < DEPTH) held_b.push_back(val);
        else dropped_load = 1'b1;
      end
      ACT_MERGE: begin
        total = held_a.size() + held_b.size();
        merges_seen++;
        if (dropped_load) overflow_merges++;
        r.ovf = dropped_load;
        if (total == 0) begin
          r.val = '0;
          r.last = 1'b1;
          r.empty = 1'b1;
          merged_expect.push_back(r);
          empty_merges++;
        end else begin
          r.empty = 1'b0;
          for (k = 0; k < total; k++) begin
            // A wins only when strictly smaller, ties go to B
            if (held_a.size() != 0 && (held_b.size() == 0 || held_a[0] < held_b[0]))
              r.val = held_a.pop_front();
            else
              r.val = held_b.pop_front();
            r.last = (k == total - 1);
            merged_expect.push_back(r);
          end
        end
        held_a.delete();
        held_b.delete();
        dropped_load = 1'b0;
      end
      default: ;
    endcase
  endtask

  task automatic add_word(input ssm_action_t act, input ssm_word_t val, input bit drain);
    load_word_t w;
    w.act = act;
    w.val = val;
    w.drain = drain;
    word_queue.push_back(w);
    words_total++;
    if (act != ACT_UNUSED) words_counted++;
  endtask

  function automatic ssm_word_t rand_word();
    case ($urandom_range(0, 7))
      0: return WORD_MIN;
      1: return WORD_MAX;
      2, 3: return ssm_word_t'(int'($urandom_range(0, 16)) - 8);
      default: return ssm_word_t'($urandom);
    endcase
  endfunction

  // add a word to run A or run B, keeping the run in order when asked
  task automatic grow_run(input bit to_b, input bit ordered);
    ssm_word_t v;
    int j;
    v = rand_word();
    if (!to_b) begin
      j = run_a.size();
      if (ordered)
        for (j = 0; j < run_a.size() && run_a[j] <= v; j++) ;
      run_a.insert(j, v);
    end else begin
      j = run_b.size();
      if (ordered)
        for (j = 0; j < run_b.size() && run_b[j] <= v; j++) ;
      run_b.insert(j, v);
    end
  endtask

  function automatic int run_length();
    case ($urandom_range(0, 19))
      0, 1, 2: return $urandom_range(5, DEPTH);
      3: return $urandom_range(DEPTH + 1, DEPTH + 4);  // spills past the store
      default: return $urandom_range(0, 4);
    endcase
  endfunction

  // one load-and-merge run with the two runs interleaved at random
  task automatic build_run(input bit drain);
    int na;
    int nb;
    bit ordered;
    int i;
    na = run_length();
    nb = run_length();
    ordered = ($urandom_range(0, 6) != 0);
    run_a.delete();
    run_b.delete();
    for (i = 0; i < na; i++) grow_run(1'b0, ordered);
    for (i = 0; i < nb; i++) grow_run(1'b1, ordered);
    while (run_a.size() != 0 || run_b.size() != 0) begin
      if ($urandom_range(0, 24) == 0) add_word(ACT_UNUSED, ssm_word_t'($urandom), 1'b0);
      if (run_b.size() == 0 || (run_a.size() != 0 && $urandom_range(0, 1) == 0))
        add_word(ACT_APPEND_A, run_a.pop_front(), 1'b0);
      else
        add_word(ACT_APPEND_B, run_b.pop_front(), 1'b0);
    end
    add_word(ACT_MERGE, ssm_word_t'($urandom), drain);
  endtask

  // driver: present the next word, hold it until accepted
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        predict_word(action, value);
        words_accepted++;
      end
      if (!start || !busy) begin
        if (word_queue.size() != 0 && gap_left == 0 &&
            !(word_queue[0].drain && merged_expect.size() != 0)) begin
          start <= 1'b1;
          action <= word_queue[0].act;
          value <= word_queue[0].val;
          word_queue.pop_front();
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end else begin
          start <= 1'b0;
          if (gap_left > 0) gap_left--;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      errors++;
      if (errors <= 30)
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  // monitor: every strobed result against the oldest expectation
  always @(posedge clk) begin
    if (!rst && strobe) begin
      results_seen++;
      if (merged_expect.size() == 0) begin
        errors++;
        if (errors <= 30)
          $display("%0t: unexpected result, expected none, got value %0h last %0b",
                   $time, merged_value, last);
      end else begin
        got_out = merged_expect.pop_front();
        check_field("merged_value", got_out.val, merged_value);
        check_field("last", {31'd0, got_out.last}, {31'd0, last});
        check_field("empty_res", {31'd0, got_out.empty}, {31'd0, empty_res});
        check_field("overflowed", {31'd0, got_out.ovf}, {31'd0, overflowed});
      end
    end
  end

  initial begin : stimulus
    int i;
    int directed_count;

    // ignored action code, then a merge of two empty stores
    add_word(ACT_UNUSED, 32'sh5A5A_A5A5, 1'b0);
    add_word(ACT_MERGE, ssm_word_t'($urandom), 1'b0);
    // equal heads at both extremes: B goes first, A finishes the run
    add_word(ACT_APPEND_A, WORD_MIN, 1'b0);
    add_word(ACT_APPEND_B, WORD_MIN, 1'b0);
    add_word(ACT_APPEND_A, WORD_MAX, 1'b0);
    add_word(ACT_APPEND_B, WORD_MAX, 1'b0);
    add_word(ACT_MERGE, ssm_word_t'($urandom), 1'b1);
    // B filled past its depth with A empty
    for (i = -1; i <= DEPTH - 1; i++) add_word(ACT_APPEND_B, ssm_word_t'(i), 1'b0);
    add_word(ACT_MERGE, '0, 1'b0);
    directed_count = words_counted;

    // random runs; the first random merge waits for the block to drain
    build_run(1'b1);
    while (words_counted - directed_count < RANDOM_WORDS)
      build_run($urandom_range(0, 7) == 0);

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    wait (words_accepted == words_total);
    while (merged_expect.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("%0d words driven, %0d merges (%0d empty, %0d after dropped loads)",
             words_total, merges_seen, empty_merges, overflow_merges);
    $display("%0d merge results checked, %0d mismatches", results_seen, errors);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
